>>> hdl/tim_pkg.sv
`timescale 1ns / 1ps
package tim_pkg;
   localparam int MaxOrder = 7;
   localparam int FlatBits = 32;
   localparam int SizeBits = 16;
   localparam int OrderBits = 3;
   localparam int CsrIdxBits = 3;
   localparam int DimIdxBits = 3;
   localparam int CntBits = 6;

   localparam logic [CsrIdxBits-1:0] CsrOrder = 3'd0;
   localparam logic CmdCompose = 1'b0;

   typedef struct packed {
      logic load;        // capture request beat
      logic step_init;   // start work on dimension dim
      logic mul_step;    // one compose multiply-accumulate step
      logic div_step;    // one restoring divider bit
      logic div_done;    // store remainder of dimension dim
      logic [DimIdxBits-1:0] dim;
      logic tot_init;    // start total/stride recompute
      logic tot_step;    // one stride product
   } cmd_type;

   typedef struct packed {
      logic is_decomp;
      logic [DimIdxBits-1:0] order;
   } stat_type;
endpackage

>>> hdl/tim_ctrl.sv
`timescale 1ns / 1ps
module tim_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic csr_wr_en,
   input  tim_pkg::stat_type stat,
   output tim_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {S_TOT, S_IDLE, S_INIT, S_MUL, S_DIV, S_NEXT, S_OUT} state_type;
   state_type state_ff;
   logic [tim_pkg::DimIdxBits-1:0] dim_ff;
   logic [tim_pkg::CntBits-1:0] cnt_ff;

   assign req_tready = (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      cmd = '0;
      cmd.dim = dim_ff;
      cmd.load = req_tvalid && req_tready;
      cmd.tot_init = csr_wr_en;
      cmd.tot_step = (state_ff == S_TOT) && !csr_wr_en;
      cmd.step_init = (state_ff == S_INIT);
      cmd.mul_step = (state_ff == S_MUL);
      cmd.div_step = (state_ff == S_DIV);
      cmd.div_done = (state_ff == S_NEXT) && stat.is_decomp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_TOT;
         dim_ff <= '0;
         cnt_ff <= '0;
      end else if (csr_wr_en) begin
         // Any register write restarts the stride sweep.
         state_ff <= S_TOT;
         dim_ff <= '0;
      end else begin
         case (state_ff)
            S_TOT: begin
               if (dim_ff == tim_pkg::DimIdxBits'(tim_pkg::MaxOrder - 1)) begin
                  state_ff <= S_IDLE;
                  dim_ff <= '0;
               end else begin
                  dim_ff <= dim_ff + 1'b1;
               end
            end
            S_IDLE: if (req_tvalid) begin
               state_ff <= S_INIT;
               dim_ff <= '0;
            end
            S_INIT: begin
               cnt_ff <= '0;
               state_ff <= stat.is_decomp ? S_DIV : S_MUL;
            end
            S_MUL: state_ff <= S_NEXT;
            S_DIV: begin
               if (cnt_ff == tim_pkg::CntBits'(tim_pkg::FlatBits - 1)) state_ff <= S_NEXT;
               cnt_ff <= cnt_ff + 1'b1;
            end
            S_NEXT: begin
               if (dim_ff == stat.order - 1'b1) begin
                  state_ff <= S_OUT;
               end else begin
                  dim_ff <= dim_ff + 1'b1;
                  state_ff <= S_INIT;
               end
            end
            S_OUT: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && !csr_wr_en |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("accepting while result pending");
   a_dim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_DIV) |-> dim_ff < stat.order)
      else $error("dimension beyond order");
endmodule

>>> hdl/tim_dp.sv
`timescale 1ns / 1ps
module tim_dp (
   input  logic clock,
   input  logic csr_wr_en,
   input  logic [tim_pkg::CsrIdxBits-1:0] csr_addr,
   input  logic [tim_pkg::SizeBits-1:0] csr_wdata,
   input  logic [tim_pkg::SizeBits*tim_pkg::MaxOrder+tim_pkg::FlatBits:0] req_fields,
   input  tim_pkg::cmd_type cmd,
   input  logic reset,
   output tim_pkg::stat_type stat,
   output logic [tim_pkg::FlatBits-1:0] flat_out,
   output logic [tim_pkg::SizeBits-1:0] sub_out [tim_pkg::MaxOrder],
   output logic range_error,
   output logic [tim_pkg::FlatBits-1:0] total_size
);
   localparam int FB = tim_pkg::FlatBits;
   localparam int SB = tim_pkg::SizeBits;
   localparam int MO = tim_pkg::MaxOrder;
   localparam int DimIdxBitsL = tim_pkg::DimIdxBits;

   logic [tim_pkg::OrderBits-1:0] order_ff;
   logic [SB-1:0] size_ff [MO];
   logic [FB-1:0] stride_ff [MO];
   logic [FB-1:0] prod_ff;
   logic over_ff, tot_over_ff;
   logic [FB-1:0] total_ff;
   logic [FB-1:0] prod_in;
   logic [FB+SB-1:0] prod_wide;
   logic [FB+SB-1:0] mul_wide;

   logic cmd_ff;
   logic [FB-1:0] flat_ff, quo_ff, acc_ff, mul_ff;
   logic [SB-1:0] rem_ff;
   logic [SB-1:0] sub_ff [MO];
   logic [SB-1:0] res_ff [MO];
   logic err_ff;
   logic [SB-1:0] cur_size, cur_sub;
   logic [DimIdxBitsL-1:0] ord_use;
   logic [SB:0] part_in;

   always_comb begin
      ord_use = order_ff;
      if (order_ff == '0) ord_use = DimIdxBitsL'(1);
      cur_size = (size_ff[cmd.dim] == '0) ? SB'(1) : size_ff[cmd.dim];
      cur_sub = sub_ff[cmd.dim];
      prod_wide = prod_ff * cur_size;
      prod_in = prod_wide[FB-1:0];
      mul_wide = stride_ff[cmd.dim] * cur_sub;
      part_in = {rem_ff, quo_ff[FB-1]} ;
   end
   assign stat.is_decomp = cmd_ff;
   assign stat.order = ord_use;

   // Restoring divider: partial remainder sits in rem_ff, dividend shifts out of quo_ff.
   logic [SB:0] trial;
   assign trial = part_in - {1'b0, cur_size};

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= tim_pkg::OrderBits'(1);
         for (int k = 0; k < MO; k++) size_ff[k] <= SB'(1);
      end else if (csr_wr_en) begin
         if (csr_addr == tim_pkg::CsrOrder) order_ff <= csr_wdata[tim_pkg::OrderBits-1:0];
         else size_ff[csr_addr - 1'b1] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.tot_init) begin
         prod_ff <= FB'(1);
         over_ff <= 1'b0;
         tot_over_ff <= 1'b0;
         total_ff <= FB'(1);
      end else if (cmd.tot_step) begin
         stride_ff[cmd.dim] <= prod_ff;
         prod_ff <= prod_in;
         if (cmd.dim < ord_use) begin
            if (prod_wide[FB+SB-1:FB] != '0) over_ff <= 1'b1;
         end
         if (cmd.dim == ord_use - 1'b1) begin
            total_ff <= prod_in;
            tot_over_ff <= over_ff || (prod_wide[FB+SB-1:FB] != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_fields[0];
         flat_ff <= req_fields[FB:1];
         for (int k = 0; k < MO; k++) begin
            sub_ff[k] <= req_fields[FB+1+SB*k +: SB];
            res_ff[k] <= '0;
         end
         acc_ff <= '0;
         rem_ff <= '0;
         quo_ff <= req_fields[FB:1];
         err_ff <= tot_over_ff
            || (req_fields[0] != tim_pkg::CmdCompose && req_fields[FB:1] >= total_ff);
      end else begin
         if (cmd.step_init) begin
            rem_ff <= '0;
            mul_ff <= mul_wide[FB-1:0];
            if (!cmd_ff && cur_sub >= cur_size) err_ff <= 1'b1;
         end
         if (cmd.mul_step) acc_ff <= acc_ff + mul_ff;
         if (cmd.div_step) begin
            if (!trial[SB]) begin
               rem_ff <= trial[SB-1:0];
               quo_ff <= {quo_ff[FB-2:0], 1'b1};
            end else begin
               rem_ff <= part_in[SB-1:0];
               quo_ff <= {quo_ff[FB-2:0], 1'b0};
            end
         end
         if (cmd.div_done) res_ff[cmd.dim] <= rem_ff;
      end
   end

   assign flat_out = cmd_ff ? flat_ff : acc_ff;
   assign range_error = err_ff;
   assign total_size = total_ff;
   always_comb for (int k = 0; k < MO; k++) sub_out[k] = res_ff[k];
endmodule

>>> hdl/tensor_index_mapper.sv
`timescale 1ns / 1ps
// Channel   Direction  Contents
// req       in         tuser: cmd; tdata: flat_in, sub_in0..sub_in6
// rsp       out        tuser: range_error; tdata: flat_out, sub_out0..6, total_size
// csr       in         write enable, register index, 16-bit data
// Compose steps through INIT, MUL and NEXT per used dimension; decompose steps through INIT,
// DIV for each bit of the one-bit-a-cycle restoring divider and NEXT, plus IDLE and OUT at entry and exit.
// After reset and after every register write a stride sweep over all seven dimensions runs, with req held off.
// Reset is synchronous and active high; one item is in flight at a time.
// A stalled result is held in place until rsp_tready, unless a register write restarts the stride sweep.
module tensor_index_mapper (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // cmd[0]
   input  logic req_tuser,
   // flat_in[31:0], sub_in0..6 [47:32] .. [143:128]
   input  logic [143:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // range_error[0]
   output logic rsp_tuser,
   // flat_out[31:0], sub_out0..6 [47:32] .. [143:128], total_size[175:144]
   output logic [175:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [2:0] csr_addr,
   input  logic [15:0] csr_wdata
);
   tim_pkg::cmd_type cmd;
   tim_pkg::stat_type stat;
   logic [31:0] flat_out, total_size;
   logic [15:0] sub_out [7];
   logic range_error;

   tim_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .csr_wr_en(csr_wr_en),
      .stat(stat), .cmd(cmd)
   );

   tim_dp u_dp (
      .clock(clock), .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_fields({req_tdata, req_tuser}), .cmd(cmd), .reset(reset), .stat(stat),
      .flat_out(flat_out), .sub_out(sub_out), .range_error(range_error),
      .total_size(total_size)
   );

   assign rsp_tuser = range_error;
   assign rsp_tdata = {total_size, sub_out[6], sub_out[5], sub_out[4],
                       sub_out[3], sub_out[2], sub_out[1], sub_out[0], flat_out};
endmodule
